// ----- sv/mrt_pkg.sv -----
// shared types and constants for the 4x4 row transform core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mrt_pkg;

    localparam int DATA_W        = 32;
    localparam int LANES         = 4;
    localparam int COEFS         = LANES * LANES;
    localparam int COEF_IDX_W    = 4;
    localparam int FRAC_BITS_DEF = 16;

    // input tdata layout, lowest bit first
    localparam int COEF_IDX_LSB = 0;
    localparam int COEF_VAL_LSB = COEF_IDX_LSB + COEF_IDX_W;
    localparam int VEC_LSB      = COEF_VAL_LSB + DATA_W;
    localparam int S_FIELDS_W   = VEC_LSB + LANES * DATA_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = LANES * DATA_W;

    // item kind carried in s_axis_tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XFORM = 1'b1;

    typedef logic [LANES-1:0][DATA_W-1:0] quad_t;

    // pipeline stage enables shared by all lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } lane_ctrl_t;

endpackage

// ----- sv/mrt_lane.sv -----
// one output column: four products, floor shift, exact sum, saturation
// depends on mrt_pkg
`timescale 1ns / 1ps

module mrt_lane #(
    parameter int FRAC_BITS = mrt_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  mrt_pkg::lane_ctrl_t           ctrl,
    input  mrt_pkg::quad_t                vec,
    input  mrt_pkg::quad_t                coef,
    output logic [mrt_pkg::DATA_W-1:0]    res,
    output logic                          sat
);
    import mrt_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic signed [PROD_W-1:0] prod_reg [LANES];
    logic signed [PROD_W-1:0] term     [LANES];
    logic signed [PROD_W:0]   pair_next [2];
    logic signed [PROD_W:0]   pair_reg  [2];
    logic signed [PROD_W+1:0] total;
    logic [PROD_W+1-(DATA_W-1):0] hi_bits;
    logic [DATA_W-1:0]        res_next, res_reg;
    logic                     sat_next, sat_reg;

    // stage 1: one multiplier per vector element
    always_ff @(posedge aclk) begin
        if (ctrl.en1) begin
            for (int k = 0; k < LANES; k++) begin
                prod_reg[k] <= PROD_W'($signed(vec[k])) * PROD_W'($signed(coef[k]));
            end
        end
    end

    // stage 2: arithmetic shift rounds toward minus infinity, pairwise add
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            term[k] = prod_reg[k] >>> FRAC_BITS;
        end
        pair_next[0] = $signed({term[0][PROD_W-1], term[0]})
                     + $signed({term[1][PROD_W-1], term[1]});
        pair_next[1] = $signed({term[2][PROD_W-1], term[2]})
                     + $signed({term[3][PROD_W-1], term[3]});
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en2) begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
    end

    // stage 3: final add and clamp to 32 bits
    always_comb begin
        total = $signed({pair_reg[0][PROD_W], pair_reg[0]})
              + $signed({pair_reg[1][PROD_W], pair_reg[1]});
        hi_bits = total[PROD_W+1:DATA_W-1];
        if ((&hi_bits) || !(|hi_bits)) begin
            res_next = total[DATA_W-1:0];
            sat_next = 1'b0;
        end else if (total[PROD_W+1]) begin
            res_next = {1'b1, {(DATA_W-1){1'b0}}};
            sat_next = 1'b1;
        end else begin
            res_next = {1'b0, {(DATA_W-1){1'b1}}};
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en3) begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

// ----- sv/mrt_merge.sv -----
// merges the four lane results and flags into one transfer, with skid buffer
// depends on mrt_pkg
`timescale 1ns / 1ps

module mrt_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mrt_pkg::quad_t                    lane_res,
    input  logic [mrt_pkg::LANES-1:0]         lane_sat,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mrt_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [0:0]                        m_axis_tuser
);
    import mrt_pkg::*;

    logic                 out_valid_reg, skid_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, skid_data_reg;
    logic                 out_ovf_reg, skid_ovf_reg;
    logic [M_TDATA_W-1:0] in_data;
    logic                 in_ovf;
    logic                 pop;

    assign in_data  = lane_res;
    assign in_ovf   = |lane_sat;
    assign pop      = out_valid_reg && m_axis_tready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg   <= skid_data_reg;
                out_ovf_reg    <= skid_ovf_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || pop) begin
                out_data_reg  <= in_data;
                out_ovf_reg   <= in_ovf;
                out_valid_reg <= 1'b1;
            end else begin
                skid_data_reg  <= in_data;
                skid_ovf_reg   <= in_ovf;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_ovf_reg;

endmodule

// ----- sv/matrix4x4_row_transform_core.sv -----
// top level of the 4x4 row-vector by matrix transform core
// depends on mrt_pkg, mrt_lane and mrt_merge
`timescale 1ns / 1ps

// usage
//   s_axis carries two kinds of transfer, chosen by s_axis_tuser:
//     load (tuser 0)      writes coef_value into matrix entry coef_index,
//                         row-major; it produces no output transfer
//     transform (tuser 1) takes row vector (vec_x..vec_w) and returns
//                         out[j] = sum_k v[k] * m[4k+j] in q16.16
//   m_axis returns one transfer per transform: four saturated elements in
//   tdata and the overflow flag in tuser
//   throughput: one transfer of either kind per cycle while m_axis is not
//   stalled; the sixteen multipliers (four per lane) each take a new
//   operand pair every cycle that the pipeline moves
//   steps of a transform: multiply at the accept edge, shift and pair add,
//   final add and clamp, output register
//   a load takes effect for every transform accepted after it
//   reset clears the matrix to zero and empties the pipeline
//   when m_axis stalls the output register and a skid entry fill first,
//   then bubbles in the pipeline are squeezed out before s_axis_tready drops
module matrix4x4_row_transform_core #(
    parameter int FRAC_BITS = mrt_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // coef_index[3:0], coef_value[35:4], vec_x[67:36], vec_y[99:68],
    // vec_z[131:100], vec_w[163:132], zero pad up to bit 167
    input  logic [mrt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  logic [0:0]                     s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [mrt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // overflow[0]
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);
    import mrt_pkg::*;

    logic                  accept;
    logic [COEF_IDX_W-1:0] coef_idx;
    logic [DATA_W-1:0]     coef_val;
    quad_t                 vec;
    logic [DATA_W-1:0]     coef_reg [COEFS];

    lane_ctrl_t            ctrl;
    logic                  v1_reg, v2_reg, v3_reg;
    logic                  merge_ready;

    quad_t                 lane_res;
    logic [LANES-1:0]      lane_sat;

    // field unpacking
    assign coef_idx = s_axis_tdata[COEF_IDX_LSB +: COEF_IDX_W];
    assign coef_val = s_axis_tdata[COEF_VAL_LSB +: DATA_W];
    assign vec      = s_axis_tdata[VEC_LSB +: M_TDATA_W];

    // a stage moves when it is empty or the stage after it moves
    assign ctrl.en3      = !v3_reg || merge_ready;
    assign ctrl.en2      = !v2_reg || ctrl.en3;
    assign ctrl.en1      = !v1_reg || ctrl.en2;
    assign s_axis_tready = ctrl.en1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // stage valid flags; only transforms enter the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ctrl.en1) begin
                v1_reg <= accept && (s_axis_tuser[0] == OP_XFORM);
            end
            if (ctrl.en2) begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // matrix coefficients; a transform samples them at its own accept edge
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < COEFS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (accept && (s_axis_tuser[0] == OP_LOAD)) begin
            coef_reg[coef_idx] <= coef_val;
        end
    end

    // one lane per output column, each reading matrix column j
    for (genvar j = 0; j < LANES; j++) begin : g_lane
        quad_t col;
        for (genvar k = 0; k < LANES; k++) begin : g_col
            assign col[k] = coef_reg[LANES * k + j];
        end
        mrt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk (aclk),
            .ctrl (ctrl),
            .vec  (vec),
            .coef (col),
            .res  (lane_res[j]),
            .sat  (lane_sat[j])
        );
    end

    // combine lanes into the result transfer
    mrt_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (v3_reg),
        .in_ready      (merge_ready),
        .lane_res      (lane_res),
        .lane_sat      (lane_sat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- tb/matrix4x4_row_transform_core_test.sv -----
// self-checking testbench for matrix4x4_row_transform_core: loads and row transforms
// checked against a q16.16 row-by-matrix predictor, with random idling on both sides
// depends on mrt_pkg and the matrix4x4_row_transform_core rtl
`timescale 1ns / 1ps

module matrix4x4_row_transform_core_test;

    import mrt_pkg::*;

    localparam int    FRAC     = FRAC_BITS_DEF;
    localparam longint SAT_HI  = 2147483647;
    localparam longint SAT_LO  = -SAT_HI - 1;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] MAX_Q16 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_Q16 = 32'h8000_0000;
    localparam logic [31:0] NEG_LSB = 32'hFFFF_FFFF;

    // one expected result: four lanes plus the saturation flag
    typedef struct packed {
        quad_t elem;
        logic  ovf;
    } row_result_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = OP_LOAD;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    // shadow of the coefficient matrix, row-major, cleared at start like the reset core
    logic [DATA_W-1:0]     matrix_shadow [COEFS];
    row_result_t           expected_rows [$];

    // idling controls shared by the test tasks and the sink process
    bit source_idle_en = 1'b1;
    bit sink_idle_en   = 1'b1;
    int sink_hold_req  = 0;

    int mismatches     = 0;
    int loads_sent     = 0;
    int rows_sent      = 0;
    int rows_checked   = 0;
    int rows_saturated = 0;
    int input_stalls   = 0;

    string lane_name [LANES] = '{"out_x", "out_y", "out_z", "out_w"};

    matrix4x4_row_transform_core #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #(20_000_000);
        $display("matrix4x4_row_transform_core_test failed");
        $finish;
    end

    // row vector times the shadow matrix: each product floored by the fraction
    // width, the four terms summed exactly, then clamped to signed 32 bits
    function automatic row_result_t row_times_matrix(input quad_t vec);
        row_result_t res;
        longint      acc;
        longint      term;
        res.ovf = 1'b0;
        for (int j = 0; j < LANES; j++) begin
            acc = 0;
            for (int k = 0; k < LANES; k++) begin
                term = longint'($signed(vec[k])) *
                       longint'($signed(matrix_shadow[LANES*k + j]));
                acc  = acc + (term >>> FRAC);
            end
            if (acc > SAT_HI) begin
                res.elem[j] = MAX_Q16;
                res.ovf     = 1'b1;
            end else if (acc < SAT_LO) begin
                res.elem[j] = MIN_Q16;
                res.ovf     = 1'b1;
            end else begin
                res.elem[j] = acc[DATA_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_item(input logic [3:0] idx,
                                                      input logic [31:0] val,
                                                      input quad_t vec);
        logic [S_TDATA_W-1:0] t;
        t = '0;
        t[COEF_IDX_LSB +: COEF_IDX_W]   = idx;
        t[COEF_VAL_LSB +: DATA_W]       = val;
        t[VEC_LSB +: LANES*DATA_W]      = vec;
        return t;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // extremes, zero, full-range noise and small q16.16 values near unity
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: w = MAX_Q16;
            1: w = MIN_Q16;
            2: w = '0;
            3, 4, 5: w = $urandom;
            default: begin
                w = $urandom_range(0, 32'h7FFFF);
                w = w - 32'h40000;
            end
        endcase
        return w;
    endfunction

    function automatic quad_t random_row();
        quad_t v;
        for (int k = 0; k < LANES; k++)
            v[k] = pick_word();
        return v;
    endfunction

    function automatic quad_t make_row(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z, input logic [31:0] w);
        quad_t v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        v[3] = w;
        return v;
    endfunction

    // offers one transfer on s_axis and updates the predictor when it is taken;
    // entered and left at a rising edge so valid can stay high between items
    task automatic offer_transfer(input logic op, input logic [3:0] idx,
                                  input logic [31:0] val, input quad_t vec);
        int gap;
        gap = source_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= pack_item(4'($urandom), 32'($urandom), random_row());
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= pack_item(idx, val, vec);
        do @(posedge aclk); while (!s_axis_tready);
        if (op == OP_LOAD) begin
            matrix_shadow[idx] = val;
            loads_sent++;
        end else begin
            expected_rows.push_back(row_times_matrix(vec));
            rows_sent++;
        end
    endtask

    // vector fields of a load are don't-care, so they carry noise
    task automatic load_coef(input logic [3:0] idx, input logic [31:0] val);
        offer_transfer(OP_LOAD, idx, val, random_row());
    endtask

    // coefficient fields of a transform are don't-care as well
    task automatic transform_row(input quad_t vec);
        offer_transfer(OP_XFORM, 4'($urandom), 32'($urandom), vec);
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s at %0t: expected %h, got %h", field, $time, want, got);
    endtask

    // result checker: each output transfer against the oldest expected row
    always @(posedge aclk) begin : check_rows
        row_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_rows.size() == 0) begin
                note_mismatch("unexpected transfer", '0, m_axis_tdata[31:0]);
            end else begin
                want = expected_rows.pop_front();
                for (int j = 0; j < LANES; j++)
                    if (m_axis_tdata[j*DATA_W +: DATA_W] !== want.elem[j])
                        note_mismatch(lane_name[j], want.elem[j],
                                      m_axis_tdata[j*DATA_W +: DATA_W]);
                if (m_axis_tuser[0] !== want.ovf)
                    note_mismatch("overflow", 32'(want.ovf), 32'(m_axis_tuser[0]));
                rows_checked++;
                if (want.ovf)
                    rows_saturated++;
            end
        end
    end

    // cycles where the core refused an offered transfer
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && !s_axis_tready)
            input_stalls++;
    end

    // sink side: random stalls, a plain always-ready mode, and a long hold on request
    initial begin : drive_sink
        int stall;
        int held;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (sink_hold_req > 0) begin
                m_axis_tready <= 1'b0;
                held          = sink_hold_req;
                sink_hold_req = 0;
                repeat (held) @(posedge aclk);
            end else if (!sink_idle_en) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // the matrix must read as all zero straight out of reset
    task automatic test_reset_state();
        transform_row(make_row(ONE_Q16, MAX_Q16, MIN_Q16, NEG_LSB));
        transform_row(random_row());
    endtask

    // identity matrix passes the row through, extremes included
    task automatic test_identity_extremes();
        for (int i = 0; i < LANES; i++)
            load_coef(4'(LANES*i + i), ONE_Q16);
        transform_row(make_row(MAX_Q16, MIN_Q16, NEG_LSB, '0));
        transform_row(make_row('0, NEG_LSB, MIN_Q16, MAX_Q16));
    endtask

    // out_x becomes x + y: at and just past both clamp limits
    task automatic test_saturation_edges();
        load_coef(4'd4, ONE_Q16);
        transform_row(make_row(MAX_Q16, '0, 32'd5, 32'd6));
        transform_row(make_row(MAX_Q16, 32'd1, 32'd5, 32'd6));
        transform_row(make_row(MIN_Q16, '0, 32'd7, 32'd8));
        transform_row(make_row(MIN_Q16, NEG_LSB, 32'd7, 32'd8));
    endtask

    // extreme coefficients in the corners, and a tiny negative product that
    // must floor to -1 rather than truncate to zero
    task automatic test_floor_rounding();
        load_coef(4'd15, MAX_Q16);
        load_coef(4'd0, MIN_Q16);
        load_coef(4'd6, 32'd1);
        transform_row(make_row(MAX_Q16, MAX_Q16, MAX_Q16, MAX_Q16));
        transform_row(make_row(MIN_Q16, MIN_Q16, MIN_Q16, MIN_Q16));
        transform_row(make_row(NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB));
        transform_row(make_row('0, NEG_LSB, '0, '0));
    endtask

    // full-rate stream in both directions, no idling anywhere
    task automatic test_back_to_back();
        source_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        repeat (50) begin
            if ($urandom_range(0, 99) < 30)
                load_coef(4'($urandom_range(0, 15)), pick_word());
            else
                transform_row(random_row());
        end
        source_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
    endtask

    // bursts of transforms, now and then preceded by a whole-matrix reload, with
    // stray single loads mixed in so matrices change mid-stream
    task automatic test_random_mix();
        int sent;
        int burst;
        sent = 0;
        while (sent < 320) begin
            if ($urandom_range(0, 99) < 25) begin
                for (int i = 0; i < COEFS; i++)
                    load_coef(4'(i), pick_word());
                sent += COEFS;
            end
            burst = $urandom_range(4, 12);
            repeat (burst) begin
                if ($urandom_range(0, 99) < 15)
                    load_coef(4'($urandom_range(0, 15)), pick_word());
                else
                    transform_row(random_row());
            end
            sent += burst;
        end
    endtask

    // long sink hold while the source keeps offering, so the pipeline and
    // skid entry fill and s_axis_tready has to drop
    task automatic test_output_backpressure();
        source_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        sink_hold_req  = 200;
        repeat (60)
            transform_row(random_row());
        source_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
    endtask

    initial begin : run_tests
        for (int i = 0; i < COEFS; i++)
            matrix_shadow[i] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_identity_extremes();
        test_saturation_edges();
        test_floor_rounding();
        test_back_to_back();
        test_random_mix();
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge aclk);
        // the core holds up to five transfers; leave room for any stray one
        repeat (12) @(posedge aclk);

        $display("covered %0d coefficient loads and %0d row transforms, %0d rows checked",
                 loads_sent, rows_sent, rows_checked);
        $display("%0d rows clamped, input held off for %0d cycles, %0d mismatches",
                 rows_saturated, input_stalls, mismatches);
        if (mismatches == 0)
            $display("matrix4x4_row_transform_core_test passed");
        else
            $display("matrix4x4_row_transform_core_test failed");
        $finish;
    end

endmodule

// ----- matrix4x4_row_transform_core.f -----
sv/mrt_pkg.sv
sv/mrt_lane.sv
sv/mrt_merge.sv
sv/matrix4x4_row_transform_core.sv
tb/matrix4x4_row_transform_core_test.sv
